FILE: rtl/mck_pkg.sv
package mck_pkg;

   // Dit length register: width and reset value, plus the reset multiples
   localparam int unsigned DitWidth = 11;
   localparam int unsigned DurWidth = 14;
   localparam logic [DitWidth-1:0] DitReset = 11'd60;
   localparam logic [DurWidth-1:0] Dur1Reset = 14'd60;
   localparam logic [DurWidth-1:0] Dur3Reset = 14'd180;
   localparam logic [DurWidth-1:0] Dur7Reset = 14'd420;

   // Number of element slots below the top bit of a code word
   localparam logic [2:0] ElemSlots = 3'd7;

   // Decoded character handed from the lookup to the serializer
   typedef struct packed {
      logic       word_gap;
      logic [7:0] code;
   } lookup_type;

   // Sequencer states, one-hot
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ALIGN = 6'b000010,
      ST_ON    = 6'b000100,
      ST_OFF   = 6'b001000,
      ST_GAP   = 6'b010000,
      ST_WORD  = 6'b100000
   } state_type;

   // Code words for A..Z (0..25) and 0..9 (26..35); the rest hold zero
   function automatic logic [7:0] code_rom(input logic [5:0] idx);
      logic [7:0] w;
      case (idx)
         6'd0:  w = 8'h05;
         6'd1:  w = 8'h18;
         6'd2:  w = 8'h1A;
         6'd3:  w = 8'h0C;
         6'd4:  w = 8'h02;
         6'd5:  w = 8'h12;
         6'd6:  w = 8'h0E;
         6'd7:  w = 8'h10;
         6'd8:  w = 8'h04;
         6'd9:  w = 8'h17;
         6'd10: w = 8'h0D;
         6'd11: w = 8'h14;
         6'd12: w = 8'h07;
         6'd13: w = 8'h06;
         6'd14: w = 8'h0F;
         6'd15: w = 8'h16;
         6'd16: w = 8'h1D;
         6'd17: w = 8'h0A;
         6'd18: w = 8'h08;
         6'd19: w = 8'h03;
         6'd20: w = 8'h09;
         6'd21: w = 8'h11;
         6'd22: w = 8'h0B;
         6'd23: w = 8'h19;
         6'd24: w = 8'h1B;
         6'd25: w = 8'h1C;
         6'd26: w = 8'h3F;
         6'd27: w = 8'h2F;
         6'd28: w = 8'h27;
         6'd29: w = 8'h23;
         6'd30: w = 8'h21;
         6'd31: w = 8'h20;
         6'd32: w = 8'h30;
         6'd33: w = 8'h38;
         6'd34: w = 8'h3C;
         6'd35: w = 8'h3E;
         default: w = 8'h00;
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/mck_lookup.sv
module mck_lookup (
   input  logic [7:0]         character,
   output mck_pkg::lookup_type result
);

   logic [7:0] upper;
   logic [7:0] letter_idx;
   logic [7:0] digit_idx;

   // Fold lowercase to uppercase
   always_comb begin
      upper = character;
      if (character inside {[8'h61:8'h7A]}) begin
         upper = character - 8'd32;
      end
   end

   assign letter_idx = upper - 8'h41;
   assign digit_idx  = upper - 8'h30 + 8'd26;

   // Map to a code word, or flag a word gap
   always_comb begin
      result.word_gap = 1'b0;
      result.code     = 8'h00;
      if (upper inside {[8'h41:8'h5A]}) begin
         result.code = mck_pkg::code_rom(letter_idx[5:0]);
      end else if (upper inside {[8'h30:8'h39]}) begin
         result.code = mck_pkg::code_rom(digit_idx[5:0]);
      end else begin
         case (upper)
            8'h0D, 8'h0A, 8'h21: result.code = 8'h6B;
            8'h22: result.code = 8'h52;
            8'h24: result.code = 8'h89;
            8'h26: result.code = 8'h28;
            8'h27: result.code = 8'h5E;
            8'h28: result.code = 8'h36;
            8'h29: result.code = 8'h6D;
            8'h2C: result.code = 8'h73;
            8'h2D: result.code = 8'h61;
            8'h2E: result.code = 8'h55;
            8'h3A: result.code = 8'h78;
            8'h3B: result.code = 8'h6A;
            8'h3F: result.code = 8'h4C;
            8'h40: result.code = 8'h5A;
            8'h5F: result.code = 8'h4D;
            default: result.word_gap = 1'b1;
         endcase
      end
   end

endmodule

FILE: rtl/mck_serializer.sv
module mck_serializer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  mck_pkg::lookup_type                  item,
   output logic                                 busy,
   input  logic                                 csr_write_enable,
   input  logic [mck_pkg::DitWidth-1:0]         csr_dit_length_ms,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_key_on,
   output logic [mck_pkg::DurWidth-1:0]         rsp_duration_ms,
   output logic                                 rsp_last
);

   mck_pkg::state_type state_ff, state_in;
   logic [7:0] shift_ff, shift_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [mck_pkg::DurWidth-1:0] dur1_ff, dur3_ff, dur7_ff;
   logic [mck_pkg::DurWidth-1:0] dur1_in, dur3_in, dur7_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic key_on_ff, key_on_in;
   logic [mck_pkg::DurWidth-1:0] dur_ff, dur_in;
   logic last_ff, last_in;
   logic out_free;

   // Precompute 1, 3 and 7 dit durations; a zero dit counts as 1 ms
   always_comb begin
      dur1_in = {{(mck_pkg::DurWidth-mck_pkg::DitWidth){1'b0}}, csr_dit_length_ms};
      if (csr_dit_length_ms == '0) begin
         dur1_in = {{(mck_pkg::DurWidth-1){1'b0}}, 1'b1};
      end
      dur3_in = dur1_in + {dur1_in[mck_pkg::DurWidth-2:0], 1'b0};
      dur7_in = {dur1_in[mck_pkg::DurWidth-4:0], 3'b000} - dur1_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dur1_ff <= mck_pkg::Dur1Reset;
         dur3_ff <= mck_pkg::Dur3Reset;
         dur7_ff <= mck_pkg::Dur7Reset;
      end else if (csr_write_enable) begin
         dur1_ff <= dur1_in;
         dur3_ff <= dur3_in;
         dur7_ff <= dur7_in;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequence the code word one element per step
   always_comb begin
      state_in     = state_ff;
      shift_in     = shift_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      key_on_in    = key_on_ff;
      dur_in       = dur_ff;
      last_in      = last_ff;
      case (state_ff)
         mck_pkg::ST_IDLE: begin
            if (start) begin
               shift_in = item.code;
               cnt_in   = mck_pkg::ElemSlots;
               state_in = item.word_gap ? mck_pkg::ST_WORD : mck_pkg::ST_ALIGN;
            end
         end
         mck_pkg::ST_ALIGN: begin
            // drop leading zeros, then the sentinel
            shift_in = {shift_ff[6:0], 1'b0};
            if (shift_ff[7]) begin
               state_in = (cnt_ff == 3'd0) ? mck_pkg::ST_GAP : mck_pkg::ST_ON;
            end else if (cnt_ff == 3'd0) begin
               state_in = mck_pkg::ST_GAP;
            end else begin
               cnt_in = cnt_ff - 3'd1;
            end
         end
         mck_pkg::ST_ON: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               key_on_in    = 1'b1;
               dur_in       = shift_ff[7] ? dur3_ff : dur1_ff;
               last_in      = 1'b0;
               state_in     = mck_pkg::ST_OFF;
            end
         end
         mck_pkg::ST_OFF: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               key_on_in    = 1'b0;
               dur_in       = dur1_ff;
               last_in      = 1'b0;
               shift_in     = {shift_ff[6:0], 1'b0};
               cnt_in       = cnt_ff - 3'd1;
               state_in     = (cnt_ff == 3'd1) ? mck_pkg::ST_GAP : mck_pkg::ST_ON;
            end
         end
         mck_pkg::ST_GAP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               key_on_in    = 1'b0;
               dur_in       = dur3_ff;
               last_in      = 1'b1;
               state_in     = mck_pkg::ST_IDLE;
            end
         end
         mck_pkg::ST_WORD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               key_on_in    = 1'b0;
               dur_in       = dur7_ff;
               last_in      = 1'b1;
               state_in     = mck_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mck_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mck_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload and shift state
   always_ff @(posedge clock) begin
      shift_ff  <= shift_in;
      cnt_ff    <= cnt_in;
      key_on_ff <= key_on_in;
      dur_ff    <= dur_in;
      last_ff   <= last_in;
   end

   assign busy            = (state_ff != mck_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_key_on      = key_on_ff;
   assign rsp_duration_ms = dur_ff;
   assign rsp_last        = last_ff;

endmodule

FILE: rtl/morse_character_keyer.sv
// Morse character keyer.
// Input channel (req_): one ASCII character per word, taken when req_valid
// is high and req_stall is low. req_stall is high while a character is being
// sent, so one character is in work at a time.
// Output channel (rsp_): one key segment per word, with key level, duration
// in ms and a last flag on the final segment of the character.
// Configuration: csr_write_enable loads csr_dit_length_ms; write only while idle.
// Sequence: after acceptance the code word is scanned one bit per cycle in a
// shift register to drop leading zeros and the sentinel, then one segment
// leaves per cycle while rsp_stall does not hold the output. A word gap is
// sent as a single segment.
// Reset: synchronous, clears the sequencer and output valid, and sets the dit
// length to 60 ms.
// When rsp_stall is high the current segment holds in the output register
// and the sequencer waits before issuing the next segment; nothing is dropped.
module morse_character_keyer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_character,
   input  logic                          csr_write_enable,
   input  logic [mck_pkg::DitWidth-1:0]  csr_dit_length_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_key_on,
   output logic [mck_pkg::DurWidth-1:0]  rsp_duration_ms,
   output logic                          rsp_last
);

   mck_pkg::lookup_type item;
   logic busy;
   logic start;

   // Decode the character
   mck_lookup u_lookup (
      .character (req_character),
      .result    (item)
   );

   assign req_stall = busy;
   assign start     = req_valid && !busy;

   // Serialize the code word into key segments
   mck_serializer u_serializer (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .item              (item),
      .busy              (busy),
      .csr_write_enable  (csr_write_enable),
      .csr_dit_length_ms (csr_dit_length_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_key_on        (rsp_key_on),
      .rsp_duration_ms   (rsp_duration_ms),
      .rsp_last          (rsp_last)
   );

endmodule
